/* rtl/tcas_pkg.sv */
// Shared types and constants for the tree common-ancestor block.
package tcas_pkg;

    // Table geometry
    localparam int NODE_W      = 10;
    localparam int TABLE_DEPTH = 1024;
    localparam int COUNT_W     = 10;
    localparam int SIZE_W      = 11;
    localparam int PARENT_W    = NODE_W + 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Input item kinds
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_EDGE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Result of one walk step from the shared step unit
    typedef struct packed {
        logic                stop;
        logic [NODE_W-1:0]   next_node;
        logic [COUNT_W-1:0]  count_sum;
    } t_step_res;

endpackage

/* rtl/tcas_ram.sv */
// Simple dual-port RAM: one write port, one registered read port.
module tcas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tcas_alu.sv */
// Shared walk-step unit: saturating count add, parent follow and step-limit check.
module tcas_alu #(
    parameter int NODES = 1024
) (
    input  logic [tcas_pkg::COUNT_W-1:0]  i_count,
    input  logic [tcas_pkg::SIZE_W-1:0]   i_add,
    input  logic [tcas_pkg::PARENT_W-1:0] i_parent,
    input  logic [$clog2(NODES)-1:0]      i_step,
    output tcas_pkg::t_step_res           o_res
);

    localparam int STEP_W = $clog2(NODES);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NODES - 1);

    logic [tcas_pkg::SIZE_W:0] sum;

    // Add with saturation at the count ceiling
    assign sum = {2'b00, i_count} + {1'b0, i_add};

    always_comb begin
        o_res.next_node = i_parent[tcas_pkg::NODE_W-1:0];
        // Stop at a root or when the walk has visited its full budget of nodes
        o_res.stop      = !i_parent[tcas_pkg::NODE_W] || (i_step == STEP_LAST);
        if (sum > {2'b00, tcas_pkg::COUNT_MAX}) begin
            o_res.count_sum = tcas_pkg::COUNT_MAX;
        end else begin
            o_res.count_sum = sum[tcas_pkg::COUNT_W-1:0];
        end
    end

endmodule

/* rtl/tree_common_ancestor_subtree.sv */
// Top level: parent-pointer tree with subtree counts and common-ancestor queries.
//
//  channel   dir  tdata (low bit up)                       tuser
//  s_axis    in   node_a[9:0], node_b[19:10], pad[23:20]    opcode[1:0]
//  m_axis    out  ancestor_node[9:0], subtree_size[20:10]   found[0]
//
//  Clear item: writes all 1024 table rows, one row per cycle. Reset starts the
//  same pass; tready stays low until it ends.
//  Edge item: reads and links the child, then reads and updates each ancestor.
//  Query item: reads and marks each node on b's chain, reads and checks each
//  node on a's chain up to the hit, reads and unmarks b's chain, then posts.
//  Each walk step costs one table read; edge, mark and unmark steps also write one row.
//  A finished query waits in the output register; the next item is taken
//  meanwhile, and a later query holds in its post cycle until that word is taken.
module tree_common_ancestor_subtree #(
    parameter int NODES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // node_a[9:0], node_b[19:10], zero pad
    input  logic [1:0]  i_s_axis_tuser,   // opcode[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // ancestor_node[9:0], subtree_size[20:10], pad
    output logic [0:0]  o_m_axis_tuser    // found[0]
);

    localparam int NODE_W   = tcas_pkg::NODE_W;
    localparam int COUNT_W  = tcas_pkg::COUNT_W;
    localparam int SIZE_W   = tcas_pkg::SIZE_W;
    localparam int PARENT_W = tcas_pkg::PARENT_W;
    localparam int DEPTH    = tcas_pkg::TABLE_DEPTH;
    localparam int STEP_W   = $clog2(NODES);
    localparam int LIMIT    = (NODES < DEPTH) ? NODES : DEPTH;
    localparam logic [NODE_W-1:0] LAST_ROW = NODE_W'(DEPTH - 1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_E_READ_CHILD,
        ST_E_LINK,
        ST_E_READ,
        ST_E_ADD,
        ST_Q_READ_B,
        ST_Q_MARK,
        ST_Q_READ_A,
        ST_Q_CHECK,
        ST_Q_READ_U,
        ST_Q_UNMARK,
        ST_Q_DONE
    } t_state;

    t_state              r_state;
    logic [NODE_W-1:0]   r_cur;
    logic [NODE_W-1:0]   r_a;
    logic [NODE_W-1:0]   r_b;
    logic [SIZE_W-1:0]   r_add;
    logic [STEP_W-1:0]   r_step;
    logic                r_found;
    logic [NODE_W-1:0]   r_anc;
    logic [SIZE_W-1:0]   r_size;
    logic                r_out_valid;
    logic                r_out_found;
    logic [NODE_W-1:0]   r_out_anc;
    logic [SIZE_W-1:0]   r_out_size;

    logic                in_word;
    logic [NODE_W-1:0]   in_a;
    logic [NODE_W-1:0]   in_b;
    logic                nodes_ok;

    logic                par_we;
    logic [PARENT_W-1:0] par_wdata;
    logic [PARENT_W-1:0] par_rdata;
    logic                cnt_we;
    logic [COUNT_W-1:0]  cnt_wdata;
    logic [COUNT_W-1:0]  cnt_rdata;
    logic                mark_we;
    logic [0:0]          mark_wdata;
    logic [0:0]          mark_rdata;

    tcas_pkg::t_step_res step_res;

    assign in_a     = i_s_axis_tdata[NODE_W-1:0];
    assign in_b     = i_s_axis_tdata[2*NODE_W-1:NODE_W];
    assign nodes_ok = (32'(in_a) < 32'(LIMIT)) && (32'(in_b) < 32'(LIMIT));

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_word         = i_s_axis_tvalid && o_s_axis_tready;

    // Drive table writes; every port addresses the current node
    always_comb begin
        par_we     = 1'b0;
        par_wdata  = {1'b1, r_a};
        cnt_we     = 1'b0;
        cnt_wdata  = step_res.count_sum;
        mark_we    = 1'b0;
        mark_wdata = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                par_we    = 1'b1;
                par_wdata = '0;
                cnt_we    = 1'b1;
                cnt_wdata = '0;
                mark_we   = 1'b1;
            end
            ST_E_LINK: begin
                par_we = !par_rdata[NODE_W];
            end
            ST_E_ADD: begin
                cnt_we = 1'b1;
            end
            ST_Q_MARK: begin
                mark_we    = 1'b1;
                mark_wdata = 1'b1;
            end
            ST_Q_UNMARK: begin
                mark_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    tcas_ram #(.WIDTH(PARENT_W), .DEPTH(DEPTH)) u_parent (
        .i_clk   (i_clk),
        .i_we    (par_we),
        .i_waddr (r_cur),
        .i_wdata (par_wdata),
        .i_raddr (r_cur),
        .o_rdata (par_rdata)
    );

    tcas_ram #(.WIDTH(COUNT_W), .DEPTH(DEPTH)) u_count (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (r_cur),
        .i_wdata (cnt_wdata),
        .i_raddr (r_cur),
        .o_rdata (cnt_rdata)
    );

    tcas_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_mark (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (r_cur),
        .i_wdata (mark_wdata),
        .i_raddr (r_cur),
        .o_rdata (mark_rdata)
    );

    tcas_alu #(.NODES(NODES)) u_alu (
        .i_count  (cnt_rdata),
        .i_add    (r_add),
        .i_parent (par_rdata),
        .i_step   (r_step),
        .o_res    (step_res)
    );

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the output word once taken, unless a new one loads now
            if (r_out_valid && i_m_axis_tready && (r_state != ST_Q_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    // Sweep all rows, then idle
                    r_cur <= r_cur + NODE_W'(1);
                    if (r_cur == LAST_ROW) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_word) begin
                        r_a     <= in_a;
                        r_b     <= in_b;
                        r_step  <= '0;
                        r_found <= 1'b0;
                        r_anc   <= '0;
                        r_size  <= '0;
                        case (i_s_axis_tuser)
                            tcas_pkg::OP_CLEAR: begin
                                r_cur   <= '0;
                                r_state <= ST_CLEAR;
                            end
                            tcas_pkg::OP_EDGE: begin
                                r_cur <= in_b;
                                if (nodes_ok) begin
                                    r_state <= ST_E_READ_CHILD;
                                end
                            end
                            tcas_pkg::OP_QUERY: begin
                                r_cur <= in_b;
                                if (nodes_ok) begin
                                    r_state <= ST_Q_READ_B;
                                end else begin
                                    r_state <= ST_Q_DONE;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_E_READ_CHILD: begin
                    r_state <= ST_E_LINK;
                end
                ST_E_LINK: begin
                    // Drop the edge if the child already hangs somewhere
                    if (par_rdata[NODE_W]) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_add   <= {1'b0, cnt_rdata} + SIZE_W'(1);
                        r_cur   <= r_a;
                        r_state <= ST_E_READ;
                    end
                end
                ST_E_READ: begin
                    r_state <= ST_E_ADD;
                end
                ST_E_ADD: begin
                    // Advance up the parent's chain
                    r_step <= r_step + STEP_W'(1);
                    if (step_res.stop) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_cur   <= step_res.next_node;
                        r_state <= ST_E_READ;
                    end
                end
                ST_Q_READ_B: begin
                    r_state <= ST_Q_MARK;
                end
                ST_Q_MARK: begin
                    if (step_res.stop) begin
                        r_cur   <= r_a;
                        r_step  <= '0;
                        r_state <= ST_Q_READ_A;
                    end else begin
                        r_cur   <= step_res.next_node;
                        r_step  <= r_step + STEP_W'(1);
                        r_state <= ST_Q_READ_B;
                    end
                end
                ST_Q_READ_A: begin
                    r_state <= ST_Q_CHECK;
                end
                ST_Q_CHECK: begin
                    // Hit on b's chain ends the search
                    if (mark_rdata[0] || step_res.stop) begin
                        if (mark_rdata[0]) begin
                            r_found <= 1'b1;
                            r_anc   <= r_cur;
                            r_size  <= {1'b0, cnt_rdata} + SIZE_W'(1);
                        end
                        r_cur   <= r_b;
                        r_step  <= '0;
                        r_state <= ST_Q_READ_U;
                    end else begin
                        r_cur   <= step_res.next_node;
                        r_step  <= r_step + STEP_W'(1);
                        r_state <= ST_Q_READ_A;
                    end
                end
                ST_Q_READ_U: begin
                    r_state <= ST_Q_UNMARK;
                end
                ST_Q_UNMARK: begin
                    if (step_res.stop) begin
                        r_state <= ST_Q_DONE;
                    end else begin
                        r_cur   <= step_res.next_node;
                        r_step  <= r_step + STEP_W'(1);
                        r_state <= ST_Q_READ_U;
                    end
                end
                ST_Q_DONE: begin
                    // Hold until the output register is free
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_found;
                        r_out_anc   <= r_anc;
                        r_out_size  <= r_size;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_size, r_out_anc};
    assign o_m_axis_tuser  = r_out_found;

endmodule

/* tb/tcas_result_checker.sv */
// Result checker for the tree common-ancestor block: tracks the tree, predicts answers.
`timescale 1ns / 100ps

module tcas_result_checker #(
    parameter int NODES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,    // node_a[9:0], node_b[19:10], zero pad
    input  logic [1:0]  i_s_tuser,    // opcode[1:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,    // ancestor_node[9:0], subtree_size[20:10], pad
    input  logic [0:0]  i_m_tuser,    // found[0]
    output int          o_fail_count,
    output int          o_answers_pending
);

    localparam int NODE_W      = tcas_pkg::NODE_W;
    localparam int SIZE_W      = tcas_pkg::SIZE_W;
    localparam int COUNT_W     = tcas_pkg::COUNT_W;
    localparam int PARENT_W    = tcas_pkg::PARENT_W;
    localparam int TABLE_DEPTH = tcas_pkg::TABLE_DEPTH;
    localparam logic [COUNT_W-1:0] COUNT_MAX = tcas_pkg::COUNT_MAX;

    typedef struct packed {
        logic              found;
        logic [NODE_W-1:0] node;
        logic [SIZE_W-1:0] size;
    } t_lca_answer;

    // Shadow copy of the tree
    logic [PARENT_W-1:0] parent_of   [TABLE_DEPTH];
    logic [COUNT_W-1:0]  desc_count  [TABLE_DEPTH];
    bit                  on_b_chain  [TABLE_DEPTH];

    // Answers still owed by the block, oldest first
    t_lca_answer lca_answers [$];

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    function automatic void clear_tree();
        foreach (parent_of[i]) begin
            parent_of[i]  = '0;
            desc_count[i] = '0;
        end
    endfunction

    // Hang child under par, then add its subtree to every ancestor (saturating)
    function automatic void link_child(input logic [NODE_W-1:0] par,
                                       input logic [NODE_W-1:0] child);
        logic [NODE_W-1:0] cur;
        int unsigned       add;
        int unsigned       sum;
        int                steps;
        if (parent_of[child][NODE_W])
            return;
        parent_of[child] = {1'b1, par};
        add = desc_count[child] + 1;
        cur = par;
        for (steps = 0; steps < NODES; steps++) begin
            sum = desc_count[cur] + add;
            desc_count[cur] = (sum > COUNT_MAX) ? COUNT_MAX : COUNT_W'(sum);
            if (!parent_of[cur][NODE_W])
                break;
            cur = parent_of[cur][NODE_W-1:0];
        end
    endfunction

    // Mark b's chain, then walk a's chain to the first marked node
    function automatic logic find_common_ancestor(input  logic [NODE_W-1:0] a,
                                                  input  logic [NODE_W-1:0] b,
                                                  output logic [NODE_W-1:0] anc);
        logic [NODE_W-1:0] cur;
        int                steps;
        foreach (on_b_chain[i])
            on_b_chain[i] = 1'b0;
        anc = '0;
        cur = b;
        for (steps = 0; steps < NODES; steps++) begin
            on_b_chain[cur] = 1'b1;
            if (!parent_of[cur][NODE_W])
                break;
            cur = parent_of[cur][NODE_W-1:0];
        end
        cur = a;
        for (steps = 0; steps < NODES; steps++) begin
            if (on_b_chain[cur]) begin
                anc = cur;
                return 1'b1;
            end
            if (!parent_of[cur][NODE_W])
                break;
            cur = parent_of[cur][NODE_W-1:0];
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : watch
        logic [1:0]        op;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
        logic [NODE_W-1:0] anc;
        logic              hit;
        t_lca_answer       want;
        t_lca_answer       got;
        if (!i_rst_n) begin
            clear_tree();
            lca_answers.delete();
            o_fail_count      = 0;
            o_answers_pending = 0;
        end else begin
            // Apply each accepted input word to the shadow tree
            if (i_s_tvalid && i_s_tready) begin
                op = i_s_tuser;
                a  = i_s_tdata[NODE_W-1:0];
                b  = i_s_tdata[2*NODE_W-1:NODE_W];
                case (op)
                    tcas_pkg::OP_CLEAR: clear_tree();
                    tcas_pkg::OP_EDGE: begin
                        if (a < NODES && b < NODES)
                            link_child(a, b);
                    end
                    tcas_pkg::OP_QUERY: begin
                        want = '0;
                        hit  = 1'b0;
                        if (a < NODES && b < NODES)
                            hit = find_common_ancestor(a, b, anc);
                        if (hit) begin
                            want.found = 1'b1;
                            want.node  = anc;
                            want.size  = SIZE_W'(desc_count[anc]) + 1'b1;
                        end
                        lca_answers.push_back(want);
                    end
                    default: ;
                endcase
            end

            // Compare each accepted result word with the oldest answer
            if (i_m_tvalid && i_m_tready) begin
                got.found = i_m_tuser[0];
                got.node  = i_m_tdata[NODE_W-1:0];
                got.size  = i_m_tdata[NODE_W+SIZE_W-1:NODE_W];
                if (lca_answers.size() == 0) begin
                    report_mismatch("result word with no query waiting");
                end else begin
                    want = lca_answers.pop_front();
                    if (got.found != want.found)
                        report_mismatch($sformatf("found %0d, want %0d",
                                                  got.found, want.found));
                    if (got.node != want.node)
                        report_mismatch($sformatf("ancestor_node %0d, want %0d",
                                                  got.node, want.node));
                    if (got.size != want.size)
                        report_mismatch($sformatf("subtree_size %0d, want %0d",
                                                  got.size, want.size));
                end
            end
            o_answers_pending = lca_answers.size();
        end
    end

endmodule

/* tb/testbench.sv */
// Top of the tree common-ancestor testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

    localparam int         NODE_COUNT = 1024;
    localparam logic [1:0] OP_CLEAR   = tcas_pkg::OP_CLEAR;
    localparam logic [1:0] OP_EDGE    = tcas_pkg::OP_EDGE;
    localparam logic [1:0] OP_QUERY   = tcas_pkg::OP_QUERY;
    localparam logic [1:0] OP_SPARE   = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;

    int fail_count;
    int answers_pending;
    int idle_pct  = 0;
    int stall_pct = 0;

    // Shadow of which nodes the random trees use, to keep them acyclic
    bit node_used   [NODE_COUNT];
    bit node_linked [NODE_COUNT];
    int tree_nodes  [$];

    tree_common_ancestor_subtree #(.NODES(NODE_COUNT)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    tcas_result_checker #(.NODES(NODE_COUNT)) u_result_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_tvalid        (s_tvalid),
        .i_s_tready        (s_tready),
        .i_s_tdata         (s_tdata),
        .i_s_tuser         (s_tuser),
        .i_m_tvalid        (m_tvalid),
        .i_m_tready        (m_tready),
        .i_m_tdata         (m_tdata),
        .i_m_tuser         (m_tuser),
        .o_fail_count      (fail_count),
        .o_answers_pending (answers_pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Stall the result channel at the current rate
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Hold one word on the input channel until it is taken, after optional idles
    task automatic send_item(input logic [1:0] op, input logic [9:0] a,
                             input logic [9:0] b);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, b, a};
        s_tuser  <= op;
        do @(posedge i_clk); while (!s_tready);
    endtask

    function automatic int fresh_node();
        int n;
        do n = $urandom_range(NODE_COUNT - 1); while (node_used[n]);
        node_used[n] = 1'b1;
        tree_nodes.push_back(n);
        return n;
    endfunction

    // Mostly grow and query well-formed trees; some noise and ignored words
    task automatic random_item(output bit counted);
        int r;
        int p;
        int c;
        r = $urandom_range(99);
        counted = 1'b1;
        if (r < 2 || tree_nodes.size() > 600) begin
            send_item(OP_CLEAR, 10'($urandom), 10'($urandom));
            foreach (node_used[i]) begin
                node_used[i]   = 1'b0;
                node_linked[i] = 1'b0;
            end
            tree_nodes.delete();
        end else if (r < 45) begin
            if (r < 40 && tree_nodes.size() > 0)
                p = tree_nodes[$urandom_range(tree_nodes.size() - 1)];
            else
                p = fresh_node();
            c = fresh_node();
            node_linked[c] = 1'b1;
            send_item(OP_EDGE, 10'(p), 10'(c));
        end else if (r < 50) begin
            counted = 1'b0;
            if (tree_nodes.size() > 0) begin
                c = tree_nodes[$urandom_range(tree_nodes.size() - 1)];
                if (node_linked[c]) begin
                    send_item(OP_EDGE, 10'($urandom), 10'(c));
                    counted = 1'b1;
                end
            end
        end else if (r < 54) begin
            send_item(OP_SPARE, 10'($urandom), 10'($urandom));
        end else if (r < 90 && tree_nodes.size() > 0) begin
            send_item(OP_QUERY, 10'(tree_nodes[$urandom_range(tree_nodes.size() - 1)]),
                      10'(tree_nodes[$urandom_range(tree_nodes.size() - 1)]));
        end else begin
            send_item(OP_QUERY, 10'($urandom), 10'($urandom));
        end
    endtask

    initial begin
        int phase;
        int done;
        bit counted;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty tree, extremes, ignored edges, spare opcode
        send_item(OP_QUERY, 10'd0, 10'd0);
        send_item(OP_QUERY, 10'd1023, 10'd1023);
        send_item(OP_QUERY, 10'd0, 10'd1023);
        send_item(OP_EDGE, 10'd1023, 10'd0);
        send_item(OP_EDGE, 10'd1023, 10'h2AA);
        send_item(OP_EDGE, 10'd0, 10'h155);
        send_item(OP_QUERY, 10'h155, 10'h2AA);
        send_item(OP_QUERY, 10'h2AA, 10'h155);
        send_item(OP_QUERY, 10'h155, 10'd0);
        send_item(OP_EDGE, 10'd5, 10'h155);
        send_item(OP_QUERY, 10'h155, 10'h155);
        send_item(OP_SPARE, 10'd1023, 10'd1023);
        send_item(OP_QUERY, 10'd1023, 10'd5);
        // Self edge walks the full step limit and saturates the count
        send_item(OP_EDGE, 10'd7, 10'd7);
        send_item(OP_QUERY, 10'd7, 10'd7);
        // Two-node loop
        send_item(OP_EDGE, 10'd9, 10'd10);
        send_item(OP_EDGE, 10'd10, 10'd9);
        send_item(OP_QUERY, 10'd9, 10'd10);
        send_item(OP_QUERY, 10'd1023, 10'd10);
        send_item(OP_CLEAR, 10'h3FF, 10'h3FF);
        send_item(OP_QUERY, 10'h155, 10'h2AA);

        // Drain every answer before the random part
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (answers_pending == 0);
        @(posedge i_clk);

        // Random phases: no idling, sender idle, receiver stall, both light
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 88; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            done = 0;
            while (done < 475) begin
                random_item(counted);
                if (counted)
                    done++;
            end
        end

        // Drop valid, drain, then allow for a trailing clear pass
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (answers_pending == 0);
        repeat (2500) @(posedge i_clk);

        if (fail_count == 0 && answers_pending == 0)
            $display("tree_common_ancestor_subtree regression: pass");
        else
            $display("tree_common_ancestor_subtree regression: fail");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #20_000_000;
        $display("tree_common_ancestor_subtree regression: fail");
        $finish;
    end

endmodule
